// ----- hw/rtl/ptrc_pkg.sv -----
// ptrc_pkg: operation, limit kind, reject reason and register index codes
// plus the fixed table sizes and saturation bounds of the risk checker
// no dependencies
package ptrc_pkg;

    localparam int NUM_SYMBOLS = 64;
    localparam int SYM_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_W       = 63;

    // position saturates at +-(2^39-1), exposure at +-(2^63-1)
    localparam logic signed [40:0] POS_HI  = 41'sd549755813887;
    localparam logic signed [64:0] EXP_HI  = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic [45:0]        TOTP_MAX = 46'h3FFF_FFFF_FFFF;
    localparam logic [62:0]        TOTE_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        OP_CHECK     = 3'd0,
        OP_FILL      = 3'd1,
        OP_SET_LIMIT = 3'd2,
        OP_TICK      = 3'd3,
        OP_CLEAR     = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        LK_POSITION = 2'd0,
        LK_SIZE     = 2'd1,
        LK_NOTIONAL = 2'd2
    } t_lim_kind;

    typedef enum logic [2:0] {
        RSN_NONE         = 3'd0,
        RSN_RATE         = 3'd1,
        RSN_SIZE         = 3'd2,
        RSN_POSITION     = 3'd3,
        RSN_GLB_POSITION = 3'd4,
        RSN_NOTIONAL     = 3'd5,
        RSN_GLB_NOTIONAL = 3'd6
    } t_reason;

    typedef enum logic [2:0] {
        CFG_DEF_POS_LIM  = 3'd0,
        CFG_DEF_SIZE_LIM = 3'd1,
        CFG_DEF_NOTL_LIM = 3'd2,
        CFG_GLB_POS_LIM  = 3'd3,
        CFG_GLB_NOTL_LIM = 3'd4,
        CFG_RATE_LIM     = 3'd5
    } t_cfg_idx;

endpackage

// ----- hw/rtl/pre_trade_risk_checker.sv -----
// pre_trade_risk_checker: order checks, fill bookkeeping and per-symbol limits
// depends on ptrc_pkg
//
// Usage: items enter on the input channel (i_in_valid / o_in_stall) and each
// gives exactly one result on the output channel (o_out_valid / i_out_stall).
// A transfer happens at a rising edge with valid high and stall low.
// Pipeline: input register, then a stage that holds the price x quantity
// product and the per-symbol table reads, then the result register. One item
// is taken every cycle while the receiver does not stall, set by the single
// read port of each symbol table, with the item ahead forwarded to the one
// behind it.
// The output register frees as its result transfers, so a new item is taken
// in the same cycle. When the receiver stalls with a result pending, the
// whole pipeline holds and o_in_stall rises.
// Configuration writes use i_cfg_we / i_cfg_idx / i_cfg_wdata and are taken
// at once; indexes six and seven are ignored. Synchronous reset clears the
// pipeline, the limit registers to their defaults, positions, exposures,
// totals, the rate counter and the per-symbol limit flags. No clearing pass.
module pre_trade_risk_checker
    import ptrc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_operation,
    input  logic [SYM_W-1:0]      i_symbol_index,
    input  logic                  i_side,
    input  logic [23:0]           i_quantity,
    input  logic [31:0]           i_price,
    input  logic [1:0]            i_limit_kind,
    input  logic [62:0]           i_limit_value,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_accepted,
    output logic [2:0]            o_reject_reason,
    output logic signed [39:0]    o_position,
    output logic signed [63:0]    o_exposure,
    output logic [62:0]           o_exposure_sum
);

    // configuration registers
    logic [38:0] r_def_pos_lim;
    logic [23:0] r_def_size_lim;
    logic [62:0] r_def_notl_lim;
    logic [44:0] r_glb_pos_lim;
    logic [62:0] r_glb_notl_lim;
    logic [31:0] r_rate_lim;

    // trading state
    logic [NUM_SYMBOLS-1:0] r_ent_vld;
    logic [2:0]             r_lim_flg [NUM_SYMBOLS];
    logic [45:0]            r_tot_pos;
    logic [62:0]            r_tot_exp;
    logic [31:0]            r_orders;

    // symbol tables
    logic signed [39:0] r_mem_pos  [NUM_SYMBOLS];
    logic signed [63:0] r_mem_exp  [NUM_SYMBOLS];
    logic [38:0]        r_mem_plim [NUM_SYMBOLS];
    logic [23:0]        r_mem_slim [NUM_SYMBOLS];
    logic [62:0]        r_mem_nlim [NUM_SYMBOLS];

    // stage 1: input register
    logic              r_s1_vld;
    logic [2:0]        r_s1_op;
    logic [SYM_W-1:0]  r_s1_sym;
    logic              r_s1_side;
    logic [23:0]       r_s1_qty;
    logic [31:0]       r_s1_price;
    logic [1:0]        r_s1_kind;
    logic [62:0]       r_s1_lval;

    // stage 2: product, table reads and forwarded values
    logic               r_s2_vld;
    logic [2:0]         r_s2_op;
    logic [SYM_W-1:0]   r_s2_sym;
    logic               r_s2_side;
    logic [23:0]        r_s2_qty;
    logic [1:0]         r_s2_kind;
    logic [62:0]        r_s2_lval;
    logic [55:0]        r_s2_prod;
    logic signed [39:0] r_s2_pos_rd;
    logic signed [63:0] r_s2_exp_rd;
    logic [38:0]        r_s2_plim_rd;
    logic [23:0]        r_s2_slim_rd;
    logic [62:0]        r_s2_nlim_rd;
    logic               r_s2_pe_hit;
    logic signed [39:0] r_s2_hpos;
    logic signed [63:0] r_s2_hexp;
    logic               r_s2_plim_hit;
    logic               r_s2_slim_hit;
    logic               r_s2_nlim_hit;
    logic [62:0]        r_s2_hlval;

    logic r_out_vld;

    // commit stage logic
    logic               w_adv;
    logic               c_fire;
    t_op                c_op;
    t_lim_kind          c_kind;
    logic [2:0]         c_flg;
    logic signed [39:0] c_pos_old;
    logic signed [63:0] c_exp_old;
    logic [38:0]        c_plim;
    logic [23:0]        c_slim;
    logic [62:0]        c_nlim;
    logic signed [40:0] c_pos_sum;
    logic signed [64:0] c_exp_sum;
    logic signed [39:0] c_pos_new;
    logic signed [63:0] c_exp_new;
    logic [39:0]        c_pos_old_abs;
    logic [39:0]        c_pos_new_abs;
    logic [63:0]        c_exp_old_abs;
    logic [63:0]        c_exp_new_abs;
    logic [45:0]        c_totp_base;
    logic [46:0]        c_totp_sum;
    logic [45:0]        c_totp_new;
    logic [62:0]        c_tote_base;
    logic [63:0]        c_tote_sum;
    logic [62:0]        c_tote_new;
    logic               c_rate_on;
    logic               c_rate_fail;
    t_reason            c_reason;
    logic               c_is_fill;
    logic               c_is_setlim;

    // pipeline moves as one unless a result waits on a stalled receiver
    assign w_adv      = !r_out_vld || !i_out_stall;
    assign o_in_stall = !w_adv;
    assign c_fire     = r_s2_vld && w_adv;
    assign c_op       = t_op'(r_s2_op);
    assign c_kind     = t_lim_kind'(r_s2_kind);
    assign c_is_fill  = c_fire && (c_op == OP_FILL);
    assign c_is_setlim = c_fire && (c_op == OP_SET_LIMIT);

    // resolved table values for the committing item
    always_comb begin
        c_flg     = r_lim_flg[r_s2_sym];
        c_pos_old = r_s2_pe_hit ? r_s2_hpos : (r_ent_vld[r_s2_sym] ? r_s2_pos_rd : '0);
        c_exp_old = r_s2_pe_hit ? r_s2_hexp : (r_ent_vld[r_s2_sym] ? r_s2_exp_rd : '0);
        c_plim    = c_flg[0] ? r_s2_plim_rd : r_def_pos_lim;
        c_slim    = c_flg[1] ? r_s2_slim_rd : r_def_size_lim;
        c_nlim    = c_flg[2] ? r_s2_nlim_rd : r_def_notl_lim;
        if (r_s2_plim_hit) begin
            c_plim = r_s2_hlval[38:0];
        end
        if (r_s2_slim_hit) begin
            c_slim = r_s2_hlval[23:0];
        end
        if (r_s2_nlim_hit) begin
            c_nlim = r_s2_hlval;
        end
    end

    // saturating moves of position and exposure
    always_comb begin
        if (r_s2_side) begin
            c_pos_sum = {c_pos_old[39], c_pos_old} - $signed({17'b0, r_s2_qty});
            c_exp_sum = {c_exp_old[63], c_exp_old} - $signed({9'b0, r_s2_prod});
        end else begin
            c_pos_sum = {c_pos_old[39], c_pos_old} + $signed({17'b0, r_s2_qty});
            c_exp_sum = {c_exp_old[63], c_exp_old} + $signed({9'b0, r_s2_prod});
        end
        if (c_pos_sum > POS_HI) begin
            c_pos_new = POS_HI[39:0];
        end else if (c_pos_sum < -POS_HI) begin
            c_pos_new = 40'(-POS_HI);
        end else begin
            c_pos_new = c_pos_sum[39:0];
        end
        if (c_exp_sum > EXP_HI) begin
            c_exp_new = EXP_HI[63:0];
        end else if (c_exp_sum < -EXP_HI) begin
            c_exp_new = 64'(-EXP_HI);
        end else begin
            c_exp_new = c_exp_sum[63:0];
        end
    end

    // magnitudes and running totals
    always_comb begin
        c_pos_old_abs = c_pos_old[39] ? (~c_pos_old + 40'd1) : c_pos_old;
        c_pos_new_abs = c_pos_new[39] ? (~c_pos_new + 40'd1) : c_pos_new;
        c_exp_old_abs = c_exp_old[63] ? (~c_exp_old + 64'd1) : c_exp_old;
        c_exp_new_abs = c_exp_new[63] ? (~c_exp_new + 64'd1) : c_exp_new;

        c_totp_base = (r_tot_pos >= {7'b0, c_pos_old_abs[38:0]})
                      ? (r_tot_pos - {7'b0, c_pos_old_abs[38:0]}) : '0;
        c_totp_sum  = {1'b0, c_totp_base} + {8'b0, c_pos_new_abs[38:0]};
        c_totp_new  = (c_totp_sum > {1'b0, TOTP_MAX}) ? TOTP_MAX : c_totp_sum[45:0];

        c_tote_base = (r_tot_exp >= c_exp_old_abs[62:0])
                      ? (r_tot_exp - c_exp_old_abs[62:0]) : '0;
        c_tote_sum  = {1'b0, c_tote_base} + {1'b0, c_exp_new_abs[62:0]};
        c_tote_new  = c_tote_sum[63] ? TOTE_MAX : c_tote_sum[62:0];
    end

    // check sequence, first failure wins
    always_comb begin
        c_rate_on   = (r_rate_lim != '0);
        c_rate_fail = c_rate_on && (r_orders >= r_rate_lim);
        c_reason    = RSN_NONE;
        if (c_op == OP_CHECK) begin
            priority if (c_rate_fail) begin
                c_reason = RSN_RATE;
            end else if (r_s2_qty > c_slim) begin
                c_reason = RSN_SIZE;
            end else if (c_pos_new_abs[38:0] > c_plim) begin
                c_reason = RSN_POSITION;
            end else if ((r_glb_pos_lim != '0) && (c_totp_new > {1'b0, r_glb_pos_lim})) begin
                c_reason = RSN_GLB_POSITION;
            end else if (c_exp_new_abs[62:0] > c_nlim) begin
                c_reason = RSN_NOTIONAL;
            end else if ((r_glb_notl_lim != '0) && (c_tote_new > r_glb_notl_lim)) begin
                c_reason = RSN_GLB_NOTIONAL;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_pos_lim  <= 39'd1000000;
            r_def_size_lim <= 24'd10000;
            r_def_notl_lim <= 63'd10000000000000;
            r_glb_pos_lim  <= '0;
            r_glb_notl_lim <= '0;
            r_rate_lim     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DEF_POS_LIM:  r_def_pos_lim  <= i_cfg_wdata[38:0];
                CFG_DEF_SIZE_LIM: r_def_size_lim <= i_cfg_wdata[23:0];
                CFG_DEF_NOTL_LIM: r_def_notl_lim <= i_cfg_wdata;
                CFG_GLB_POS_LIM:  r_glb_pos_lim  <= i_cfg_wdata[44:0];
                CFG_GLB_NOTL_LIM: r_glb_notl_lim <= i_cfg_wdata;
                CFG_RATE_LIM:     r_rate_lim     <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld  <= i_in_valid;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= r_s2_vld;
        end
    end

    // stage payloads, product and table reads
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_op    <= i_operation;
            r_s1_sym   <= i_symbol_index;
            r_s1_side  <= i_side;
            r_s1_qty   <= i_quantity;
            r_s1_price <= i_price;
            r_s1_kind  <= i_limit_kind;
            r_s1_lval  <= i_limit_value;

            r_s2_op      <= r_s1_op;
            r_s2_sym     <= r_s1_sym;
            r_s2_side    <= r_s1_side;
            r_s2_qty     <= r_s1_qty;
            r_s2_kind    <= r_s1_kind;
            r_s2_lval    <= r_s1_lval;
            r_s2_prod    <= 56'(r_s1_price * r_s1_qty);
            r_s2_pos_rd  <= r_mem_pos[r_s1_sym];
            r_s2_exp_rd  <= r_mem_exp[r_s1_sym];
            r_s2_plim_rd <= r_mem_plim[r_s1_sym];
            r_s2_slim_rd <= r_mem_slim[r_s1_sym];
            r_s2_nlim_rd <= r_mem_nlim[r_s1_sym];

            // forward the write of the item committing at this edge
            r_s2_pe_hit   <= c_is_fill && (r_s2_sym == r_s1_sym);
            r_s2_hpos     <= c_pos_new;
            r_s2_hexp     <= c_exp_new;
            r_s2_hlval    <= r_s2_lval;
            r_s2_plim_hit <= c_is_setlim && (c_kind == LK_POSITION) && (r_s2_sym == r_s1_sym);
            r_s2_slim_hit <= c_is_setlim && (c_kind == LK_SIZE) && (r_s2_sym == r_s1_sym);
            r_s2_nlim_hit <= c_is_setlim && (c_kind == LK_NOTIONAL) && (r_s2_sym == r_s1_sym);
        end
    end

    // table writes at commit
    always_ff @(posedge i_clk) begin
        if (c_is_fill) begin
            r_mem_pos[r_s2_sym] <= c_pos_new;
            r_mem_exp[r_s2_sym] <= c_exp_new;
        end
        if (c_is_setlim && (c_kind == LK_POSITION)) begin
            r_mem_plim[r_s2_sym] <= r_s2_lval[38:0];
        end
        if (c_is_setlim && (c_kind == LK_SIZE)) begin
            r_mem_slim[r_s2_sym] <= r_s2_lval[23:0];
        end
        if (c_is_setlim && (c_kind == LK_NOTIONAL)) begin
            r_mem_nlim[r_s2_sym] <= r_s2_lval;
        end
    end

    // trading state update at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_tot_pos <= '0;
            r_tot_exp <= '0;
            r_orders  <= '0;
            for (int i = 0; i < NUM_SYMBOLS; i++) begin
                r_lim_flg[i] <= '0;
            end
        end else if (c_fire) begin
            unique case (c_op)
                OP_CHECK: begin
                    if (c_rate_on && !c_rate_fail) begin
                        r_orders <= r_orders + 32'd1;
                    end
                end
                OP_FILL: begin
                    r_ent_vld[r_s2_sym] <= 1'b1;
                    r_tot_pos           <= c_totp_new;
                    r_tot_exp           <= c_tote_new;
                end
                OP_SET_LIMIT: begin
                    unique case (c_kind)
                        LK_POSITION: r_lim_flg[r_s2_sym][0] <= 1'b1;
                        LK_SIZE:     r_lim_flg[r_s2_sym][1] <= 1'b1;
                        LK_NOTIONAL: r_lim_flg[r_s2_sym][2] <= 1'b1;
                        default: ;
                    endcase
                end
                OP_TICK: begin
                    r_orders <= '0;
                end
                OP_CLEAR: begin
                    r_ent_vld <= '0;
                    r_tot_pos <= '0;
                    r_tot_exp <= '0;
                    r_orders  <= '0;
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (c_fire) begin
            o_accepted      <= (c_reason == RSN_NONE);
            o_reject_reason <= c_reason;
            unique case (c_op)
                OP_FILL: begin
                    o_position     <= c_pos_new;
                    o_exposure     <= c_exp_new;
                    o_exposure_sum <= c_tote_new;
                end
                OP_CLEAR: begin
                    o_position     <= '0;
                    o_exposure     <= '0;
                    o_exposure_sum <= '0;
                end
                default: begin
                    o_position     <= c_pos_old;
                    o_exposure     <= c_exp_old;
                    o_exposure_sum <= r_tot_exp;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;

    // checks
    a_accept_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (o_accepted == (o_reject_reason == RSN_NONE)))
        else $error("accepted flag disagrees with reject reason");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |=> ($stable(r_s2_vld) && $stable(r_s1_vld)))
        else $error("pipeline moved while result was stalled");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_fire && (c_op == OP_CLEAR)) |=> (r_ent_vld == '0 && r_orders == '0))
        else $error("clear left positions or rate counter");

    a_rate_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_fire && (c_reason == RSN_RATE)) |=> $stable(r_orders))
        else $error("rate counter moved on a rate reject");

endmodule

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for pre_trade_risk_checker
// holds its own risk book predictor; depends on ptrc_pkg and the rtl top
`timescale 1ns / 100ps

module testbench;
    import ptrc_pkg::*;

    // codes the block must ignore
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam logic [1:0] LK_UNUSED    = 2'd3;
    localparam logic [2:0] CFG_UNUSED   = 3'd6;
    localparam logic [2:0] CFG_UNUSED_HI = 3'd7;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [63:0] POS_LIM = 64'd549755813887;
    localparam logic [63:0] EXP_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TOTP_LIM = 64'h3FFF_FFFF_FFFF;
    localparam logic [63:0] MASK63 = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  sym;
        logic        side;
        logic [23:0] qty;
        logic [31:0] price;
        logic [1:0]  kind;
        logic [62:0] lval;
    } t_order_item;

    typedef struct packed {
        logic               acc;
        logic [2:0]         reason;
        logic signed [39:0] pos;
        logic signed [63:0] expo;
        logic [62:0]        tot;
    } t_risk_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [2:0]           i_operation;
    logic [SYM_W-1:0]     i_symbol_index;
    logic                 i_side;
    logic [23:0]          i_quantity;
    logic [31:0]          i_price;
    logic [1:0]           i_limit_kind;
    logic [62:0]          i_limit_value;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_accepted;
    logic [2:0]           o_reject_reason;
    logic signed [39:0]   o_position;
    logic signed [63:0]   o_exposure;
    logic [62:0]          o_exposure_sum;

    pre_trade_risk_checker u_top (.*);

    // predicted risk book
    logic [63:0]        lim_regs [6];
    logic [63:0]        lim_mask [6];
    logic signed [63:0] book_pos [64];
    logic signed [63:0] book_exp [64];
    logic [2:0]         sym_flags [64];
    logic [63:0]        sym_pos_lim [64];
    logic [63:0]        sym_size_lim [64];
    logic [63:0]        sym_notl_lim [64];
    logic [63:0]        sum_abs_pos;
    logic [63:0]        sum_abs_exp;
    logic [63:0]        window_orders;

    t_risk_result pending_results [$];
    int fail_count;
    int items_sent;
    int results_seen;
    int rejects_seen [7];
    int send_idle_pct;
    int stall_pct;
    int cycles;

    // clock and cycle limit
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic logic [63:0] abs_val(logic signed [63:0] v);
        return v < 0 ? 64'd0 - v : v;
    endfunction

    function automatic logic signed [63:0] sat_move(logic signed [63:0] cur, logic sub,
                                                    logic [63:0] amt, logic [63:0] lim);
        if (!sub) begin
            if (cur >= 0 && (cur + amt) > lim) return lim;
            return cur + $signed(amt);
        end
        if (cur <= 0 && (abs_val(cur) + amt) > lim) return -$signed(lim);
        return cur - $signed(amt);
    endfunction

    function automatic logic [63:0] adjust_total(logic [63:0] total, logic [63:0] oldm,
                                                 logic [63:0] newm, logic [63:0] maxv);
        logic [63:0] t;
        t = total >= oldm ? total - oldm : 64'd0;
        if (newm > maxv || maxv - newm < t) return maxv;
        return t + newm;
    endfunction

    task automatic reset_book();
        lim_regs = '{64'd1000000, 64'd10000, 64'd10000000000000, 64'd0, 64'd0, 64'd0};
        lim_mask = '{POS_LIM, 64'hFF_FFFF, MASK63, 64'h1FFF_FFFF_FFFF, MASK63, 64'hFFFF_FFFF};
        for (int s = 0; s < 64; s++) begin
            book_pos[s] = 0;
            book_exp[s] = 0;
            sym_flags[s] = 3'b000;
        end
        sum_abs_pos = 0;
        sum_abs_exp = 0;
        window_orders = 0;
    endtask

    // risk decision and book update for one item
    function automatic t_risk_result risk_step(t_order_item it);
        t_risk_result r;
        int s;
        logic signed [63:0] pos, ex, npos, nex;
        logic [63:0] notional, plim, slim, nlim;
        logic [2:0] reason;
        s = it.sym;
        notional = 64'(it.price) * 64'(it.qty);
        pos = book_pos[s];
        ex = book_exp[s];
        npos = sat_move(pos, it.side, 64'(it.qty), POS_LIM);
        nex = sat_move(ex, it.side, notional, EXP_LIM);
        reason = RSN_NONE;
        case (it.op)
            OP_CHECK: begin
                plim = sym_flags[s][0] ? sym_pos_lim[s] : lim_regs[CFG_DEF_POS_LIM];
                slim = sym_flags[s][1] ? sym_size_lim[s] : lim_regs[CFG_DEF_SIZE_LIM];
                nlim = sym_flags[s][2] ? sym_notl_lim[s] : lim_regs[CFG_DEF_NOTL_LIM];
                if (lim_regs[CFG_RATE_LIM] != 0 && window_orders >= lim_regs[CFG_RATE_LIM]) begin
                    reason = RSN_RATE;
                end else begin
                    if (lim_regs[CFG_RATE_LIM] != 0)
                        window_orders = (window_orders + 1) & 64'hFFFF_FFFF;
                    if (64'(it.qty) > slim)
                        reason = RSN_SIZE;
                    else if (abs_val(npos) > plim)
                        reason = RSN_POSITION;
                    else if (lim_regs[CFG_GLB_POS_LIM] != 0 &&
                             adjust_total(sum_abs_pos, abs_val(pos), abs_val(npos), TOTP_LIM)
                             > lim_regs[CFG_GLB_POS_LIM])
                        reason = RSN_GLB_POSITION;
                    else if (abs_val(nex) > nlim)
                        reason = RSN_NOTIONAL;
                    else if (lim_regs[CFG_GLB_NOTL_LIM] != 0 &&
                             adjust_total(sum_abs_exp, abs_val(ex), abs_val(nex), EXP_LIM)
                             > lim_regs[CFG_GLB_NOTL_LIM])
                        reason = RSN_GLB_NOTIONAL;
                end
            end
            OP_FILL: begin
                sum_abs_pos = adjust_total(sum_abs_pos, abs_val(pos), abs_val(npos), TOTP_LIM);
                sum_abs_exp = adjust_total(sum_abs_exp, abs_val(ex), abs_val(nex), EXP_LIM);
                book_pos[s] = npos;
                book_exp[s] = nex;
            end
            OP_SET_LIMIT: begin
                case (it.kind)
                    LK_POSITION: begin
                        sym_pos_lim[s] = 64'(it.lval) & POS_LIM;
                        sym_flags[s][0] = 1'b1;
                    end
                    LK_SIZE: begin
                        sym_size_lim[s] = 64'(it.lval) & 64'hFF_FFFF;
                        sym_flags[s][1] = 1'b1;
                    end
                    LK_NOTIONAL: begin
                        sym_notl_lim[s] = 64'(it.lval);
                        sym_flags[s][2] = 1'b1;
                    end
                    default: ;
                endcase
            end
            OP_TICK: window_orders = 0;
            OP_CLEAR: begin
                for (int k = 0; k < 64; k++) begin
                    book_pos[k] = 0;
                    book_exp[k] = 0;
                end
                sum_abs_pos = 0;
                sum_abs_exp = 0;
                window_orders = 0;
            end
            default: ;
        endcase
        r.reason = reason;
        r.acc = (reason == RSN_NONE);
        r.pos = book_pos[s][39:0];
        r.expo = book_exp[s];
        r.tot = sum_abs_exp[62:0];
        return r;
    endfunction

    // result checking against the oldest prediction
    always @(posedge i_clk) begin
        t_risk_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no prediction waiting");
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_accepted !== e.acc) begin
                    $error("accepted: expected %0d got %0d", e.acc, o_accepted);
                    fail_count++;
                end
                if (o_reject_reason !== e.reason) begin
                    $error("reject_reason: expected %0d got %0d", e.reason, o_reject_reason);
                    fail_count++;
                end
                if (o_position !== e.pos) begin
                    $error("position: expected %0d got %0d", e.pos, o_position);
                    fail_count++;
                end
                if (o_exposure !== e.expo) begin
                    $error("exposure: expected %0d got %0d", e.expo, o_exposure);
                    fail_count++;
                end
                if (o_exposure_sum !== e.tot) begin
                    $error("exposure_sum: expected %0d got %0d", e.tot, o_exposure_sum);
                    fail_count++;
                end
            end
        end
    end

    // one input transfer; valid stays high afterwards unless the next call idles
    task automatic send_item(t_order_item it);
        t_risk_result r;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= it.op;
        i_symbol_index <= it.sym;
        i_side         <= it.side;
        i_quantity     <= it.qty;
        i_price        <= it.price;
        i_limit_kind   <= it.kind;
        i_limit_value  <= it.lval;
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        r = risk_step(it);
        pending_results.push_back(r);
        if (it.op == OP_CHECK && !r.acc) rejects_seen[r.reason]++;
        items_sent++;
    endtask

    // wait until every prediction has been met
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val[62:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < 6) lim_regs[idx] = val & lim_mask[idx];
    endtask

    function automatic t_order_item mk(logic [2:0] op, logic [5:0] sym, logic side,
                                       logic [23:0] qty, logic [31:0] price,
                                       logic [1:0] kind = LK_POSITION, logic [62:0] lval = '0);
        t_order_item it;
        it.op = op;
        it.sym = sym;
        it.side = side;
        it.qty = qty;
        it.price = price;
        it.kind = kind;
        it.lval = lval;
        return it;
    endfunction

    function automatic t_order_item rand_item();
        t_order_item it;
        int w;
        w = $urandom_range(0, 99);
        if (w < 45) it.op = OP_CHECK;
        else if (w < 80) it.op = OP_FILL;
        else if (w < 87) it.op = OP_SET_LIMIT;
        else if (w < 94) it.op = OP_TICK;
        else if (w < 96) it.op = OP_CLEAR;
        else it.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        it.sym = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 7)) : 6'($urandom);
        it.side = 1'($urandom);
        w = $urandom_range(0, 9);
        it.qty = (w < 7) ? 24'($urandom_range(0, 20000)) :
                 (w < 8) ? 24'($urandom) : 24'($urandom_range(0, 2000));
        w = $urandom_range(0, 9);
        it.price = (w < 7) ? $urandom_range(0, 2000000) :
                   (w < 8) ? 32'($urandom) : $urandom_range(0, 20000);
        it.kind = 2'($urandom_range(0, 3));
        w = $urandom_range(0, 3);
        if (w == 0) it.lval = {31'($urandom), 32'($urandom)};
        else if (w == 1) it.lval = 63'($urandom_range(0, 30000));
        else it.lval = 63'({$urandom_range(0, 1023), 32'($urandom)});
        return it;
    endfunction

    // every reject reason but the global notional one, every operation and the ignored codes
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        send_item(mk(OP_CHECK, 6'd0, 1'b0, 24'd100, 32'd500000));
        send_item(mk(OP_CHECK, 6'd63, 1'b1, 24'd10001, 32'd1));
        send_item(mk(OP_FILL, 6'd63, 1'b0, 24'hFF_FFFF, 32'hFFFF_FFFF));
        send_item(mk(OP_FILL, 6'd1, 1'b1, 24'd0, 32'd0));
        send_item(mk(OP_FILL, 6'd1, 1'b1, 24'd900, 32'd10000));
        send_item(mk(OP_CHECK, 6'd1, 1'b1, 24'd9999, 32'd10000));
        send_item(mk(OP_CHECK, 6'd63, 1'b0, 24'd1, 32'd1));
        send_item(mk(OP_SET_LIMIT, 6'd2, 1'b0, 24'd0, 32'd0, LK_POSITION, 63'd50));
        send_item(mk(OP_SET_LIMIT, 6'd2, 1'b0, 24'd0, 32'd0, LK_SIZE, '1));
        send_item(mk(OP_SET_LIMIT, 6'd2, 1'b0, 24'd0, 32'd0, LK_NOTIONAL, 63'd7000));
        send_item(mk(OP_SET_LIMIT, 6'd2, 1'b0, 24'd0, 32'd0, LK_UNUSED, 63'd1));
        send_item(mk(OP_CHECK, 6'd2, 1'b0, 24'd51, 32'd1));
        send_item(mk(OP_CHECK, 6'd2, 1'b0, 24'd50, 32'd141));
        send_item(mk(OP_CHECK, 6'd2, 1'b1, 24'd50, 32'd140));
        send_item(mk(OP_UNUSED_LO, 6'd2, 1'b0, 24'd5, 32'd5));
        send_item(mk(OP_UNUSED_HI, 6'd2, 1'b1, 24'd5, 32'd5));
        write_reg(CFG_GLB_POS_LIM, 64'd1000);
        write_reg(CFG_GLB_NOTL_LIM, 64'd5000000);
        write_reg(CFG_RATE_LIM, 64'd3);
        write_reg(CFG_UNUSED, 64'd1);
        write_reg(CFG_UNUSED_HI, 64'd1);
        send_item(mk(OP_CHECK, 6'd1, 1'b1, 24'd200, 32'd1));
        send_item(mk(OP_CHECK, 6'd3, 1'b0, 24'd10, 32'd1000000));
        send_item(mk(OP_CHECK, 6'd3, 1'b0, 24'd10, 32'd1));
        send_item(mk(OP_CHECK, 6'd3, 1'b0, 24'd10, 32'd1));
        send_item(mk(OP_TICK, 6'd3, 1'b0, 24'd0, 32'd0));
        send_item(mk(OP_CHECK, 6'd3, 1'b0, 24'd10, 32'd1));
        send_item(mk(OP_CLEAR, 6'd63, 1'b0, 24'd0, 32'd0));
        send_item(mk(OP_CHECK, 6'd63, 1'b0, 24'd10, 32'd1));
        drain();
    endtask

    // drive exposures and the exposure total into saturation both ways
    task automatic test_exposure_saturation();
        write_reg(CFG_RATE_LIM, 64'd0);
        write_reg(CFG_GLB_POS_LIM, 64'h1FFF_FFFF_FFFF);
        write_reg(CFG_GLB_NOTL_LIM, MASK63);
        write_reg(CFG_DEF_NOTL_LIM, MASK63);
        write_reg(CFG_DEF_SIZE_LIM, 64'hFF_FFFF);
        write_reg(CFG_DEF_POS_LIM, POS_LIM);
        send_idle_pct = 12;
        stall_pct = 12;
        for (int n = 0; n < 130; n++) send_item(mk(OP_FILL, 6'd5, 1'b0, '1, '1));
        for (int n = 0; n < 130; n++) send_item(mk(OP_FILL, 6'd6, 1'b0, '1, '1));
        send_item(mk(OP_CHECK, 6'd5, 1'b0, '1, '1));
        for (int n = 0; n < 260; n++) send_item(mk(OP_FILL, 6'd5, 1'b1, '1, '1));
        send_item(mk(OP_CHECK, 6'd5, 1'b1, '1, '1));
        send_item(mk(OP_CLEAR, 6'd0, 1'b0, 24'd0, 32'd0));
        drain();
    endtask

    // random item stream under one setting of the limit registers
    task automatic test_random(int count, int idle_pct, int stall_p);
        write_reg(CFG_DEF_POS_LIM, ($urandom_range(0, 3) == 0) ? POS_LIM :
                  64'($urandom_range(0, 200000)));
        write_reg(CFG_DEF_SIZE_LIM, ($urandom_range(0, 3) == 0) ? 64'hFF_FFFF :
                  64'($urandom_range(0, 20000)));
        write_reg(CFG_DEF_NOTL_LIM, ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} :
                  64'($urandom_range(0, 32'hFFFF_FFFF)) * 64'd8);
        write_reg(CFG_GLB_POS_LIM, ($urandom_range(0, 1) == 0) ? 64'd0 :
                  64'($urandom_range(0, 500000)));
        write_reg(CFG_GLB_NOTL_LIM, ($urandom_range(0, 1) == 0) ? 64'd0 :
                  64'($urandom) * 64'd64);
        write_reg(CFG_RATE_LIM, ($urandom_range(0, 2) == 0) ? 64'd0 :
                  ($urandom_range(0, 5) == 0) ? 64'hFFFF_FFFF : 64'($urandom_range(1, 20)));
        send_idle_pct = idle_pct;
        stall_pct = stall_p;
        for (int n = 0; n < count; n++) begin
            send_item(rand_item());
            // let the pipeline run dry once mid-phase
            if (n == count / 2) drain();
        end
        drain();
    endtask

    initial begin
        cycles = 0;
        fail_count = 0;
        items_sent = 0;
        results_seen = 0;
        rejects_seen = '{default: 0};
        send_idle_pct = 0;
        stall_pct = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_wdata <= '0;
        i_in_valid <= 1'b0;
        i_out_stall <= 1'b0;
        i_operation <= OP_CHECK;
        i_symbol_index <= '0;
        i_side <= 1'b0;
        i_quantity <= '0;
        i_price <= '0;
        i_limit_kind <= LK_POSITION;
        i_limit_value <= '0;
        reset_book();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_exposure_saturation();
        test_random(250, 0, 0);
        test_random(250, 52, 0);
        test_random(250, 0, 52);
        test_random(250, 12, 12);
        write_reg(CFG_DEF_POS_LIM, 64'd0);
        write_reg(CFG_DEF_SIZE_LIM, 64'd0);
        write_reg(CFG_DEF_NOTL_LIM, 64'd0);
        test_random(40, 12, 12);

        $display("covered %0d items, %0d results, all operations and limit registers",
                 items_sent, results_seen);
        $display("rejects by reason rate/size/pos/gpos/notl/gnotl: %0d %0d %0d %0d %0d %0d",
                 rejects_seen[1], rejects_seen[2], rejects_seen[3], rejects_seen[4],
                 rejects_seen[5], rejects_seen[6]);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ptrc_pkg.sv
hw/rtl/pre_trade_risk_checker.sv
tb/sv/testbench.sv
